// ===== rtl/tch_pkg.sv =====
package tch_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int HEAD_FRAC_DEF   = 6;

  localparam int SAMPLE_W = 16;
  localparam int HEAD_W   = 15;
  localparam int NUM_REGS = 6;
  localparam int ADDR_W   = 5;
  localparam int IDX_W    = 3;

  localparam logic [IDX_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_Z = 3'd5;

  // datapath widths
  localparam int M_W    = 18;   // calibrated magnetometer axis
  localparam int P_W    = 34;   // axis products
  localparam int E_W    = 35;   // cross product terms
  localparam int AA_W   = 33;   // |a|^2
  localparam int AM_W   = 36;   // a.m
  localparam int NY_W   = 54;   // north y term
  localparam int SQ_STEPS = 24;
  localparam int RAD_W  = 48;
  localparam int ROOT_W = 24;
  localparam int REM_W  = 28;
  localparam int EL_W   = 17;   // low slice of |E.y| for the split multiply
  localparam int EH_W   = E_W - 1 - EL_W;
  localparam int MP_W   = EL_W + ROOT_W;
  localparam int U_W    = 62;
  localparam int NORM_LIM = 30;
  localparam int NORM_STAGES = 3;
  localparam logic [U_W-1:0] NORM_TOP = U_W'(1) << NORM_LIM;
  localparam int CORDIC_STEPS = 20;
  localparam int CX_W   = 34;
  localparam int Z_W    = 26;
  localparam int H_W    = 26;
  localparam int ANG_FRAC = 16;

  localparam logic signed [Z_W-1:0] Z_Q90 = Z_W'(90 << ANG_FRAC);
  localparam logic [H_W-1:0] H_Q90  = H_W'(90 << ANG_FRAC);
  localparam logic [H_W-1:0] H_Q270 = H_W'(270 << ANG_FRAC);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mag_x;
    logic signed [SAMPLE_W-1:0] mag_y;
    logic signed [SAMPLE_W-1:0] mag_z;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
  } tch_in_t;

  typedef struct packed {
    logic [HEAD_W-1:0] heading;
    logic              degenerate;
  } tch_out_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/tilt_compensated_heading_top.sv =====
// done_o is the tail of the vld_q shift register, which carries each accepted start alongside the datapath registers
// throughput: one transaction per cycle; busy stays low, the pipeline always advances
// the depth comes from the 24-stage square root and the 20-stage cordic, one step a stage
// the receiver cannot stall; each result is shown on result_o for one cycle with done_o
// reset clears the calibration registers to zero and drops all in-flight transactions
module tilt_compensated_heading_top #(
  parameter int SAMPLE_BITS           = tch_pkg::SAMPLE_BITS_DEF,
  parameter int HEADING_FRACTION_BITS = tch_pkg::HEAD_FRAC_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  tch_pkg::tch_in_t            sample_i,
  output logic                        done_o,
  output tch_pkg::tch_out_t           result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tch_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tch_pkg::*;

  localparam int SEXT_SH = SAMPLE_W - SAMPLE_BITS;
  localparam int RSH     = ANG_FRAC - HEADING_FRACTION_BITS;
  localparam int NR_STAGE = 5 + SQ_STEPS + 3 + NORM_STAGES;
  localparam int LAT     = NR_STAGE + CORDIC_STEPS + 2;
  localparam logic [H_W:0] HALF     = (H_W + 1)'(1) << (RSH - 1);
  localparam logic [H_W:0] HEAD_LIM = (H_W + 1)'(360) << HEADING_FRACTION_BITS;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sq_t;

  typedef struct packed {
    logic signed [E_W-1:0]  ey;
    logic signed [NY_W-1:0] ny;
    logic                   degen;
  } sd_t;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic degen;
    logic zero;
  } fl_t;

  typedef struct packed {
    logic [U_W-1:0] ux;
    logic [U_W-1:0] uy;
  } nr_t;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cr_t;

  function automatic logic signed [SAMPLE_W-1:0] sext(input logic [SAMPLE_W-1:0] v);
    logic [SAMPLE_W-1:0] t;
    t = v << SEXT_SH;
    return $signed(t) >>> SEXT_SH;
  endfunction

  // ---------------- configuration port ----------------
  logic [SAMPLE_W-1:0] cal_q [NUM_REGS];
  logic [IDX_W-1:0]    reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) cal_q[i] <= '0;
    end else if (cfg_wr && (reg_idx < IDX_W'(NUM_REGS))) begin
      cal_q[reg_idx] <= pwdata[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx < IDX_W'(NUM_REGS)) prdata = {16'd0, cal_q[reg_idx]};
  end

  // ---------------- control ----------------
  logic           accept;
  logic [LAT-1:0] vld_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign done_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  // ---------------- stage 1: remove calibration midpoint ----------------
  logic signed [SAMPLE_W-1:0] cmin [3];
  logic signed [SAMPLE_W-1:0] cmax [3];
  logic signed [SAMPLE_W:0]   csum [3];
  logic signed [SAMPLE_W:0]   cadj [3];
  logic signed [SAMPLE_W-1:0] off  [3];
  logic signed [SAMPLE_W-1:0] smag [3];
  logic signed [SAMPLE_W-1:0] sacc [3];
  logic signed [M_W-1:0]      m_d  [3];
  logic signed [M_W-1:0]      m_q  [3];
  logic signed [SAMPLE_W-1:0] a_q  [3];

  always_comb begin
    cmin[0] = sext(cal_q[REG_MIN_X]);
    cmin[1] = sext(cal_q[REG_MIN_Y]);
    cmin[2] = sext(cal_q[REG_MIN_Z]);
    cmax[0] = sext(cal_q[REG_MAX_X]);
    cmax[1] = sext(cal_q[REG_MAX_Y]);
    cmax[2] = sext(cal_q[REG_MAX_Z]);
    smag[0] = sext(sample_i.mag_x);
    smag[1] = sext(sample_i.mag_y);
    smag[2] = sext(sample_i.mag_z);
    sacc[0] = sext(sample_i.accel_x);
    sacc[1] = sext(sample_i.accel_y);
    sacc[2] = sext(sample_i.accel_z);
    for (int i = 0; i < 3; i++) begin
      csum[i] = (SAMPLE_W + 1)'(cmin[i]) + (SAMPLE_W + 1)'(cmax[i]);
      // halve toward zero
      cadj[i] = csum[i] + $signed({{SAMPLE_W{1'b0}}, csum[i][SAMPLE_W]});
      off[i]  = SAMPLE_W'(cadj[i] >>> 1);
      m_d[i]  = M_W'(smag[i]) - M_W'(off[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      m_q[i] <= m_d[i];
      a_q[i] <= sacc[i];
    end
  end

  // ---------------- stage 2: axis products ----------------
  logic signed [P_W-1:0]    mx [3];
  logic signed [P_W-1:0]    ax [3];
  logic signed [P_W-1:0]    pe_q  [6];
  logic signed [P_W-1:0]    paa_q [3];
  logic signed [P_W-1:0]    pam_q [3];
  logic signed [M_W-1:0]    m1_s2_q;
  logic signed [SAMPLE_W-1:0] a1_s2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mx[i] = P_W'(m_q[i]);
      ax[i] = P_W'(a_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    pe_q[0] <= mx[1] * ax[2];
    pe_q[1] <= mx[2] * ax[1];
    pe_q[2] <= mx[2] * ax[0];
    pe_q[3] <= mx[0] * ax[2];
    pe_q[4] <= mx[0] * ax[1];
    pe_q[5] <= mx[1] * ax[0];
    for (int i = 0; i < 3; i++) begin
      paa_q[i] <= ax[i] * ax[i];
      pam_q[i] <= ax[i] * mx[i];
    end
    m1_s2_q <= m_q[1];
    a1_s2_q <= a_q[1];
  end

  // ---------------- stage 3: sums ----------------
  logic signed [E_W-1:0]      ey_s3_q;
  logic signed [AA_W-1:0]     aa_s3_q;
  logic signed [AM_W-1:0]     am_s3_q;
  logic                       degen_s3_q;
  logic signed [M_W-1:0]      m1_s3_q;
  logic signed [SAMPLE_W-1:0] a1_s3_q;

  always_ff @(posedge clk_i) begin
    ey_s3_q    <= E_W'(pe_q[2]) - E_W'(pe_q[3]);
    aa_s3_q    <= AA_W'(paa_q[0]) + AA_W'(paa_q[1]) + AA_W'(paa_q[2]);
    am_s3_q    <= AM_W'(pam_q[0]) + AM_W'(pam_q[1]) + AM_W'(pam_q[2]);
    // east is zero exactly when each pair of products matches
    degen_s3_q <= (pe_q[0] == pe_q[1]) && (pe_q[2] == pe_q[3]) && (pe_q[4] == pe_q[5]);
    m1_s3_q    <= m1_s2_q;
    a1_s3_q    <= a1_s2_q;
  end

  // ---------------- stage 4: north y products ----------------
  logic signed [NY_W-1:0] q1_s4_q;
  logic signed [NY_W-1:0] q2_s4_q;
  logic signed [E_W-1:0]  ey_s4_q;
  logic signed [AA_W-1:0] aa_s4_q;
  logic                   degen_s4_q;

  always_ff @(posedge clk_i) begin
    q1_s4_q    <= NY_W'(m1_s3_q) * NY_W'(aa_s3_q);
    q2_s4_q    <= NY_W'(a1_s3_q) * NY_W'(am_s3_q);
    ey_s4_q    <= ey_s3_q;
    aa_s4_q    <= aa_s3_q;
    degen_s4_q <= degen_s3_q;
  end

  // ---------------- stage 5 and square root stages ----------------
  sq_t sq_q [SQ_STEPS+1];
  sd_t sd_q [SQ_STEPS+1];

  always_ff @(posedge clk_i) begin
    sq_q[0].rem   <= '0;
    sq_q[0].root  <= '0;
    sq_q[0].rad   <= {aa_s4_q[31:0], 16'd0};
    sd_q[0].ey    <= ey_s4_q;
    sd_q[0].ny    <= q1_s4_q - q2_s4_q;
    sd_q[0].degen <= degen_s4_q;
  end

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] trial;
    always_comb begin
      r2    = {sq_q[j].rem[REM_W-3:0], sq_q[j].rad[RAD_W-1 -: 2]};
      trial = REM_W'({sq_q[j].root, 2'b01});
    end
    always_ff @(posedge clk_i) begin
      if (r2 >= trial) begin
        sq_q[j+1].rem  <= r2 - trial;
        sq_q[j+1].root <= {sq_q[j].root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_q[j+1].rem  <= r2;
        sq_q[j+1].root <= {sq_q[j].root[ROOT_W-2:0], 1'b0};
      end
      sq_q[j+1].rad <= sq_q[j].rad << 2;
      sd_q[j+1]     <= sd_q[j];
    end
  end

  // ---------------- magnitudes and y = |E.y| * |a| ----------------
  logic [E_W-2:0]    eabs;
  logic [NY_W-2:0]   nabs;
  logic signed [E_W-1:0]  ey_f;
  logic signed [NY_W-1:0] ny_f;
  logic [EL_W-1:0]   elo_q;
  logic [EH_W-1:0]   ehi_q;
  logic [ROOT_W-1:0] root_q;
  logic [NY_W-2:0]   nabs_p1_q;
  logic [NY_W-2:0]   nabs_p2_q;
  logic [MP_W-1:0]   plo_q;
  logic [MP_W-1:0]   phi_q;
  fl_t               ps_q [NORM_STAGES+3];
  nr_t               nr_q [NORM_STAGES+1];

  always_comb begin
    ey_f = sd_q[SQ_STEPS].ey;
    ny_f = sd_q[SQ_STEPS].ny;
    eabs = ey_f[E_W-1]  ? (E_W-1)'(-ey_f)  : ey_f[E_W-2:0];
    nabs = ny_f[NY_W-1] ? (NY_W-1)'(-ny_f) : ny_f[NY_W-2:0];
  end

  always_ff @(posedge clk_i) begin
    elo_q          <= eabs[EL_W-1:0];
    ehi_q          <= eabs[E_W-2:EL_W];
    root_q         <= sq_q[SQ_STEPS].root;
    nabs_p1_q      <= nabs;
    ps_q[0].xneg   <= !ny_f[NY_W-1] && (ny_f != '0);
    ps_q[0].yneg   <= !ey_f[E_W-1] && (ey_f != '0) && (sq_q[SQ_STEPS].root != '0);
    ps_q[0].degen  <= sd_q[SQ_STEPS].degen;
    ps_q[0].zero   <= 1'b0;

    plo_q     <= MP_W'(elo_q) * MP_W'(root_q);
    phi_q     <= MP_W'(ehi_q) * MP_W'(root_q);
    nabs_p2_q <= nabs_p1_q;
    ps_q[1]   <= ps_q[0];

    nr_q[0].uy <= (U_W'(phi_q) << EL_W) + U_W'(plo_q);
    nr_q[0].ux <= U_W'(nabs_p2_q) << 8;
    ps_q[2]    <= ps_q[1];
  end

  // ---------------- normalize below 2^30, two binary shift steps a stage ----------------
  for (genvar n = 0; n < NORM_STAGES; n++) begin : g_norm
    localparam int KH = 32 >> (2 * n);
    localparam int KL = KH / 2;
    nr_t v1;
    nr_t v2;
    always_comb begin
      v1 = nr_q[n];
      if (((v1.ux | v1.uy) >> (KH - 1)) >= NORM_TOP) begin
        v1.ux = v1.ux >> KH;
        v1.uy = v1.uy >> KH;
      end
      v2 = v1;
      if (((v2.ux | v2.uy) >> (KL - 1)) >= NORM_TOP) begin
        v2.ux = v2.ux >> KL;
        v2.uy = v2.uy >> KL;
      end
    end
    always_ff @(posedge clk_i) begin
      nr_q[n+1] <= v2;
      ps_q[n+3] <= ps_q[n+2];
    end
  end

  // ---------------- cordic vectoring, one iteration a stage ----------------
  cr_t cin  [CORDIC_STEPS];
  cr_t cr_q [CORDIC_STEPS+1];
  fl_t cfl  [CORDIC_STEPS];
  fl_t cf_q [CORDIC_STEPS+1];

  always_comb begin
    cin[0].x = CX_W'(nr_q[NORM_STAGES].ux[NORM_LIM-1:0]);
    cin[0].y = CX_W'(nr_q[NORM_STAGES].uy[NORM_LIM-1:0]);
    cin[0].z = '0;
    cfl[0]      = ps_q[NORM_STAGES+2];
    cfl[0].zero = (nr_q[NORM_STAGES].ux == '0) && (nr_q[NORM_STAGES].uy == '0);
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      cin[i] = cr_q[i];
      cfl[i] = cf_q[i];
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;
    logic signed [Z_W-1:0]  at;
    always_comb begin
      // shift of negative y truncates toward zero
      dx = cin[i].y[CX_W-1] ? -((-cin[i].y) >>> i) : (cin[i].y >>> i);
      dy = cin[i].x >>> i;
      at = atan_lut(5'(i));
    end
    always_ff @(posedge clk_i) begin
      if (!cin[i].y[CX_W-1]) begin
        cr_q[i+1].x <= cin[i].x + dx;
        cr_q[i+1].y <= cin[i].y - dy;
        cr_q[i+1].z <= cin[i].z + at;
      end else begin
        cr_q[i+1].x <= cin[i].x - dx;
        cr_q[i+1].y <= cin[i].y + dy;
        cr_q[i+1].z <= cin[i].z - at;
      end
      cf_q[i+1] <= cfl[i];
    end
  end

  // ---------------- quadrant fold and mounting offset ----------------
  logic signed [Z_W-1:0] zraw;
  logic signed [Z_W-1:0] zc;
  logic [H_W-1:0]        zu;
  logic [H_W-1:0]        h_d;
  logic [H_W-1:0]        h_q;
  logic                  degen_f_q;
  fl_t                   ff;

  always_comb begin
    ff   = cf_q[CORDIC_STEPS];
    zraw = ff.zero ? '0 : cr_q[CORDIC_STEPS].z;
    if (zraw[Z_W-1])       zc = '0;
    else if (zraw > Z_Q90) zc = Z_Q90;
    else                   zc = zraw;
    zu = H_W'(zc);
    // heading = angle - 90, wrapped into 0..360
    unique case ({ff.xneg, ff.yneg})
      2'b00:   h_d = zu + H_Q270;
      2'b10:   h_d = H_Q90 - zu;
      2'b01:   h_d = H_Q270 - zu;
      default: h_d = zu + H_Q90;
    endcase
  end

  always_ff @(posedge clk_i) begin
    h_q       <= h_d;
    degen_f_q <= ff.degen;
  end

  // ---------------- rounding and output register ----------------
  logic [H_W:0] rnd;
  logic [H_W:0] res;
  tch_out_t     result_d;
  tch_out_t     result_q;

  always_comb begin
    rnd = ((H_W + 1)'(h_q) + HALF) >> RSH;
    res = (rnd >= HEAD_LIM) ? '0 : rnd;
    result_d.heading    = degen_f_q ? '0 : res[HEAD_W-1:0];
    result_d.degenerate = degen_f_q;
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_o = result_q;

  // ---------------- assertions ----------------
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("result strobe without a matching accepted transaction");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((H_W + 1)'(result_o.heading) < HEAD_LIM))
    else $error("heading at or above 360 degrees");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.degenerate) |-> (result_o.heading == '0))
    else $error("degenerate transaction with nonzero heading");

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NR_STAGE-1] |->
      ((nr_q[NORM_STAGES].ux | nr_q[NORM_STAGES].uy) < NORM_TOP))
    else $error("cordic input not normalized");

endmodule
